>>> rtl/ial_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer ALU package
// Opcodes, error codes, stream packing widths and shared types for the ALU.
// ----------------------------------------------------------------------------
package ial_pkg;

   localparam int OP_W        = 7;
   localparam int OPND_W      = 32;
   localparam int RES_W       = 32;
   localparam int ERR_W       = 2;
   localparam int FLAG_W      = 3;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RES_W - FLAG_W - ERR_W;

   localparam int FL_C = 0;
   localparam int FL_Z = 1;
   localparam int FL_N = 2;

   localparam logic [OP_W-1:0] OP_ADD   = 7'h00;
   localparam logic [OP_W-1:0] OP_SUB   = 7'h01;
   localparam logic [OP_W-1:0] OP_MUL   = 7'h02;
   localparam logic [OP_W-1:0] OP_UDIV  = 7'h03;
   localparam logic [OP_W-1:0] OP_UREM  = 7'h04;
   localparam logic [OP_W-1:0] OP_MUL2  = 7'h05;
   localparam logic [OP_W-1:0] OP_AND   = 7'h06;
   localparam logic [OP_W-1:0] OP_XOR   = 7'h07;
   localparam logic [OP_W-1:0] OP_OR    = 7'h08;
   localparam logic [OP_W-1:0] OP_SHL   = 7'h09;
   localparam logic [OP_W-1:0] OP_SHR   = 7'h0a;
   localparam logic [OP_W-1:0] OP_POP   = 7'h0b;
   localparam logic [OP_W-1:0] OP_CLZ   = 7'h0c;
   localparam logic [OP_W-1:0] OP_CLO   = 7'h0d;
   localparam logic [OP_W-1:0] OP_BSWAP = 7'h0e;
   localparam logic [OP_W-1:0] OP_ZCNT  = 7'h0f;
   localparam logic [OP_W-1:0] OP_CMP   = 7'h20;
   localparam logic [OP_W-1:0] OP_CMPKP = 7'h21;

   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DIV0    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;

   typedef enum logic [1:0] {
      MODE_MUL,
      MODE_DIV,
      MODE_POP,
      MODE_LZC
   } ial_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RUN,
      ST_DONE
   } ial_state_type;

   typedef struct packed {
      logic ready;
      logic load;
      logic step;
      logic finish;
   } ial_ctl_type;

endpackage
`default_nettype wire

>>> rtl/ial_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared iterative unit
// One adder stepped once a cycle for shift-add multiply, restoring divide,
// ones count and leading-zero count.
// ----------------------------------------------------------------------------
module ial_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ial_pkg::ial_ctl_type      ctl,
   input  ial_pkg::ial_mode_type     mode,
   input  logic [DATA_WIDTH-1:0]     load_sh,
   input  logic [DATA_WIDTH-1:0]     load_mc,
   output logic                      last,
   output logic [DATA_WIDTH-1:0]     acc,
   output logic [DATA_WIDTH-1:0]     sh
);
   import ial_pkg::*;

   localparam int CW = $clog2(DATA_WIDTH);
   localparam int AW = DATA_WIDTH + 1;

   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] sh_ff, sh_in;
   logic [DATA_WIDTH-1:0] mc_ff, mc_in;
   logic                  found_ff, found_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         add_x, add_y, add_sum;
   logic                  add_cin;
   logic                  neg;

   always_comb begin
      add_x   = {1'b0, acc_ff};
      add_y   = '0;
      add_cin = 1'b0;
      case (mode)
         MODE_MUL: begin
            add_y = sh_ff[0] ? {1'b0, mc_ff} : '0;
         end
         MODE_DIV: begin
            add_x   = {acc_ff, sh_ff[DATA_WIDTH-1]};
            add_y   = ~{1'b0, mc_ff};
            add_cin = 1'b1;
         end
         MODE_POP: begin
            add_cin = sh_ff[0];
         end
         MODE_LZC: begin
            add_cin = !found_ff && !sh_ff[DATA_WIDTH-1];
         end
         default: begin
            add_cin = 1'b0;
         end
      endcase
   end

   assign add_sum = add_x + add_y + AW'(add_cin);
   assign neg     = add_sum[DATA_WIDTH];

   always_comb begin
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      mc_in    = mc_ff;
      found_in = found_ff;
      cnt_in   = cnt_ff;
      if (ctl.load) begin
         acc_in   = '0;
         sh_in    = load_sh;
         mc_in    = load_mc;
         found_in = 1'b0;
         cnt_in   = '0;
      end else if (ctl.step) begin
         cnt_in = cnt_ff + CW'(1);
         case (mode)
            MODE_MUL: begin
               acc_in = add_sum[DATA_WIDTH-1:0];
               mc_in  = mc_ff << 1;
               sh_in  = sh_ff >> 1;
            end
            MODE_DIV: begin
               acc_in = neg ? add_x[DATA_WIDTH-1:0] : add_sum[DATA_WIDTH-1:0];
               sh_in  = {sh_ff[DATA_WIDTH-2:0], ~neg};
            end
            MODE_POP: begin
               acc_in = add_sum[DATA_WIDTH-1:0];
               sh_in  = sh_ff >> 1;
            end
            MODE_LZC: begin
               acc_in   = add_sum[DATA_WIDTH-1:0];
               found_in = found_ff | sh_ff[DATA_WIDTH-1];
               sh_in    = sh_ff << 1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         found_ff <= found_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mc_ff  <= mc_in;
   end

   assign last = (cnt_ff == CW'(DATA_WIDTH - 1));
   assign acc  = acc_ff;
   assign sh   = sh_ff;

endmodule
`default_nettype wire

>>> rtl/ial_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ALU sequencer
// Steps each item through execute, iterate (iterative items only) and write-back.
// ----------------------------------------------------------------------------
module ial_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 iterative,
   input  logic                 last,
   input  logic                 out_free,
   output ial_pkg::ial_ctl_type ctl
);
   import ial_pkg::*;

   ial_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = iterative ? ST_RUN : ST_DONE;
         end
         ST_RUN: begin
            if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctl.ready = 1'b1;
         end
         ST_EXEC: begin
            ctl.load = iterative;
         end
         ST_RUN: begin
            ctl.step = 1'b1;
         end
         ST_DONE: begin
            ctl.finish = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/integer_alu_with_flags.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer ALU with flags
// Integer ALU with an N/Z/C flag register, iterative multiply, divide and
// bit counts.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds req_tready low until that
// item's result has been written to the output register. Add, subtract,
// logic, shift, byte swap and compare items, and items that end in an error,
// go from execute straight to write-back. Multiply, divide, remainder, ones
// and zero counts and leading counts also pass through the iterate state,
// where they run through one shared adder that handles one bit per cycle.
// The next item is accepted once the block is back in idle after the result
// is written; a result that is still held delays the write of the next.
// Division by zero gives error code 1 and an unknown opcode error code 2;
// both return zero and leave the flags unchanged.
module integer_alu_with_flags #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // op [6:0], operand_a [38:7], operand_b [70:39], zero [71]
   input  logic [ial_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result [31:0], flag_carry [32], flag_zero [33], flag_negative [34],
   // error_code [36:35], zero [39:37]
   output logic [ial_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import ial_pkg::*;

   localparam int SW     = $clog2(DATA_WIDTH);
   localparam int NBYTES = DATA_WIDTH / 8;
   localparam logic [DATA_WIDTH-1:0] WIDTH_VAL = DATA_WIDTH'(DATA_WIDTH);
   localparam logic [DATA_WIDTH-1:0] TOP_BIT   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   ial_ctl_type           ctl;
   ial_mode_type          mode;
   logic                  iterative;
   logic                  last;
   logic                  out_free;
   logic [DATA_WIDTH-1:0] load_sh;
   logic [DATA_WIDTH-1:0] unit_acc, unit_sh;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [FLAG_W-1:0]     flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_WIDTH-1:0] sum, diff, shl_val, shr_val, bswap_val, r;
   logic                  carry, slt, div_zero, basic, c_new;
   logic [FLAG_W-1:0]     cmp_flags;
   logic [ERR_W-1:0]      err;

   assign op_in = req_tdata[OP_W-1:0];
   assign a_in  = DATA_WIDTH'(req_tdata[OP_W +: OPND_W]);
   assign b_in  = DATA_WIDTH'(req_tdata[OP_W + OPND_W +: OPND_W]);

   assign {carry, sum} = {1'b0, a_ff} + {1'b0, b_ff};
   assign diff         = a_ff - b_ff;
   assign slt          = (a_ff ^ TOP_BIT) < (b_ff ^ TOP_BIT);
   assign div_zero     = (b_ff == '0);
   assign shl_val      = (b_ff >= WIDTH_VAL) ? '0 : (a_ff << b_ff[SW-1:0]);
   assign shr_val      = (b_ff >= WIDTH_VAL) ? '0 : (a_ff >> b_ff[SW-1:0]);

   always_comb begin
      cmp_flags       = '0;
      cmp_flags[FL_C] = carry;
      cmp_flags[FL_Z] = (sum == '0);
      cmp_flags[FL_N] = sum[DATA_WIDTH-1];
   end

   always_comb begin
      bswap_val = '0;
      for (int i = 0; i < NBYTES; i++) begin
         bswap_val[8*(NBYTES-1-i) +: 8] = sum[8*i +: 8];
      end
   end

   always_comb begin
      iterative = 1'b0;
      mode      = MODE_MUL;
      load_sh   = a_ff;
      r         = '0;
      err       = ERR_NONE;
      basic     = 1'b1;
      c_new     = flag_ff[FL_C];
      flag_in   = flag_ff;
      case (op_ff)
         OP_ADD: begin
            r     = sum;
            c_new = carry;
         end
         OP_SUB: begin
            r     = diff;
            c_new = slt;
         end
         OP_MUL, OP_MUL2: begin
            iterative = 1'b1;
            r         = unit_acc;
         end
         OP_UDIV: begin
            mode = MODE_DIV;
            r    = unit_sh;
            if (div_zero) begin
               err   = ERR_DIV0;
               basic = 1'b0;
               r     = '0;
            end else begin
               iterative = 1'b1;
            end
         end
         OP_UREM: begin
            mode = MODE_DIV;
            r    = unit_acc;
            if (div_zero) begin
               err   = ERR_DIV0;
               basic = 1'b0;
               r     = '0;
            end else begin
               iterative = 1'b1;
            end
         end
         OP_AND: begin
            r = a_ff & b_ff;
         end
         OP_XOR: begin
            r = a_ff ^ b_ff;
         end
         OP_OR: begin
            r = a_ff | b_ff;
         end
         OP_SHL: begin
            r = shl_val;
         end
         OP_SHR: begin
            r = shr_val;
         end
         OP_POP: begin
            iterative = 1'b1;
            mode      = MODE_POP;
            load_sh   = sum;
            r         = unit_acc;
         end
         OP_ZCNT: begin
            iterative = 1'b1;
            mode      = MODE_POP;
            load_sh   = ~sum;
            r         = unit_acc;
         end
         OP_CLZ: begin
            iterative = 1'b1;
            mode      = MODE_LZC;
            load_sh   = sum;
            r         = unit_acc;
         end
         OP_CLO: begin
            iterative = 1'b1;
            mode      = MODE_LZC;
            load_sh   = ~sum;
            r         = unit_acc;
         end
         OP_BSWAP: begin
            r = bswap_val;
         end
         OP_CMP: begin
            r       = DATA_WIDTH'(cmp_flags);
            basic   = 1'b0;
            flag_in = cmp_flags;
         end
         OP_CMPKP: begin
            r     = DATA_WIDTH'(cmp_flags);
            basic = 1'b0;
         end
         default: begin
            err   = ERR_UNKNOWN;
            basic = 1'b0;
         end
      endcase
      if (basic) begin
         flag_in[FL_C] = c_new;
         flag_in[FL_Z] = (r == '0);
         flag_in[FL_N] = r[DATA_WIDTH-1];
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_data_in  = {{RSP_PAD_W{1'b0}}, err, flag_in, RES_W'(r)};
   assign rsp_valid_in = ctl.finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   ial_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .iterative  (iterative),
      .last       (last),
      .out_free   (out_free),
      .ctl        (ctl)
   );

   ial_unit #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_unit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .mode    (mode),
      .load_sh (load_sh),
      .load_mc (b_ff),
      .last    (last),
      .acc     (unit_acc),
      .sh      (unit_sh)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.finish) begin
            flag_ff <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && ctl.ready) begin
         op_ff <= op_in;
         a_ff  <= a_in;
         b_ff  <= b_in;
      end
      if (ctl.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = ctl.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
